@@ sv/smfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Sync marker frame aligner package
// Shared widths, register indexes, reset values and the cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package smfa_pkg;

  localparam int FRAME_LEN_DEF = 12;

  localparam int SAMPLE_W   = 16;
  localparam int TOL_W      = 10;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int M_PAYLOAD_W = SLOT_W + SAMPLE_W;
  localparam int M_TDATA_W  = ((M_PAYLOAD_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - M_PAYLOAD_W;

  localparam logic [CFG_IDX_W-1:0] REG_MARKER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] MARKER_FIRST_RST  = -16'sd3856;
  localparam logic signed [SAMPLE_W-1:0] MARKER_SECOND_RST = 16'sd3855;
  localparam logic [TOL_W-1:0]           TOLERANCE_RST     = 10'd5;

  typedef struct packed {
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/smfa_match.sv @@
// ----------------------------------------------------------------------------
// Marker word matcher
// Flags a sample that lies within the tolerance window around a marker word.
// ----------------------------------------------------------------------------
`default_nettype none

module smfa_match (
  input  wire logic signed [smfa_pkg::SAMPLE_W-1:0] sample,
  input  wire logic signed [smfa_pkg::SAMPLE_W-1:0] marker,
  input  wire logic        [smfa_pkg::TOL_W-1:0]    tolerance,
  output logic                                      hit
);
  import smfa_pkg::*;

  localparam int EXT_W = SAMPLE_W + 2;

  logic signed [EXT_W-1:0] s_ext;
  logic signed [EXT_W-1:0] m_ext;
  logic signed [EXT_W-1:0] t_ext;
  logic signed [EXT_W-1:0] lo;
  logic signed [EXT_W-1:0] hi;

  always_comb begin
    s_ext = EXT_W'(sample);
    m_ext = EXT_W'(marker);
    t_ext = signed'(EXT_W'(tolerance));
    lo    = m_ext - t_ext;
    hi    = m_ext + t_ext;
    hit   = (s_ext >= lo) && (s_ext <= hi);
  end

endmodule

`default_nettype wire

@@ sv/smfa_cell.sv @@
// ----------------------------------------------------------------------------
// Frame store cell
// Holds one slot of the frame and takes its neighbour's sample, or a new one at the tail, on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module smfa_cell (
  input  wire logic                                 clk,
  input  wire smfa_pkg::cell_ctl_t                  ctl,
  input  wire logic signed [smfa_pkg::SAMPLE_W-1:0] din,
  output logic signed [smfa_pkg::SAMPLE_W-1:0]      dout
);
  import smfa_pkg::*;

  logic signed [SAMPLE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

`default_nettype wire

@@ sv/sync_marker_frame_aligner_core.sv @@
// ----------------------------------------------------------------------------
// Sync marker frame aligner
// Aligns frames of FRAME_LEN slots between two marker words in a sample
// stream and plays each complete frame out slot by slot through a cell chain.
// ----------------------------------------------------------------------------
// Latency: the first slot of a frame appears in the cycle after the closing
// marker beat; the frame then leaves at up to one beat per cycle, FRAME_LEN beats.
// Throughput: one sample per cycle, except during frame readout, when the
// input stalls until the last slot beat is taken.
// Reset: synchronous, clears the fill index, the arm flag and the readout,
// and loads the marker and tolerance registers with their default values.
`default_nettype none

module sync_marker_frame_aligner_core #(
  parameter int FRAME_LEN = smfa_pkg::FRAME_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // sample [15:0]
  input  wire logic [smfa_pkg::SAMPLE_W-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // slot [3:0], frame_sample [19:4], zero padding [23:20]
  output logic [smfa_pkg::M_TDATA_W-1:0]         m_tdata,
  output logic                                   m_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [smfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [smfa_pkg::SAMPLE_W-1:0]     cfg_data
);
  import smfa_pkg::*;

  localparam int FW = $clog2(FRAME_LEN + 2);
  localparam int CW = $clog2(FRAME_LEN);

  logic signed [SAMPLE_W-1:0] marker_first;
  logic signed [SAMPLE_W-1:0] marker_second;
  logic [TOL_W-1:0]           tolerance;
  logic [FW-1:0]              fill_index;
  logic [FW-1:0]              fill_inc;
  logic                       armed;
  logic                       emitting;
  logic [CW-1:0]              count;
  logic                       in_acc;
  logic                       out_acc;
  logic                       hit_first;
  logic                       hit_second;
  logic                       count_last;
  logic signed [SAMPLE_W-1:0] sample;
  cell_ctl_t                  cell_ctl;
  logic signed [SAMPLE_W-1:0] chain_in  [FRAME_LEN];
  logic signed [SAMPLE_W-1:0] chain_out [FRAME_LEN];

  assign sample     = signed'(s_tdata);
  assign s_tready   = !emitting;
  assign cfg_ready  = 1'b1;
  assign in_acc     = s_tvalid && s_tready;
  assign out_acc    = m_tvalid && m_tready;
  assign count_last = (count == CW'(FRAME_LEN - 1));
  assign fill_inc   = (fill_index < FW'(FRAME_LEN + 1)) ? fill_index + 1'b1 : fill_index;

  smfa_match u_match_first (
    .sample    (sample),
    .marker    (marker_first),
    .tolerance (tolerance),
    .hit       (hit_first)
  );

  smfa_match u_match_second (
    .sample    (sample),
    .marker    (marker_second),
    .tolerance (tolerance),
    .hit       (hit_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_first  <= MARKER_FIRST_RST;
      marker_second <= MARKER_SECOND_RST;
      tolerance     <= TOLERANCE_RST;
      fill_index    <= '0;
      armed         <= 1'b0;
      emitting      <= 1'b0;
      count         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MARKER_FIRST:  marker_first  <= signed'(cfg_data);
          REG_MARKER_SECOND: marker_second <= signed'(cfg_data);
          REG_TOLERANCE:     tolerance     <= cfg_data[TOL_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (!armed) begin
          armed      <= hit_first;
          fill_index <= fill_inc;
        end else if (hit_first) begin
          fill_index <= fill_inc;
        end else if (hit_second) begin
          armed      <= 1'b0;
          fill_index <= '0;
          if (fill_inc == FW'(FRAME_LEN)) begin
            emitting <= 1'b1;
            count    <= '0;
          end
        end else begin
          armed      <= 1'b0;
          fill_index <= fill_inc;
        end
      end
      if (out_acc) begin
        if (count_last) begin
          emitting <= 1'b0;
          count    <= '0;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // New samples enter at the tail; after a full frame slot k sits in cell k.
  assign cell_ctl.shift = (in_acc && (fill_index < FW'(FRAME_LEN))) || out_acc;

  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
    if (i == FRAME_LEN - 1) begin : g_tail
      assign chain_in[i] = sample;
    end else begin : g_body
      assign chain_in[i] = chain_out[i+1];
    end
    smfa_cell u_cell (
      .clk  (clk),
      .ctl  (cell_ctl),
      .din  (chain_in[i]),
      .dout (chain_out[i])
    );
  end

  assign m_tvalid = emitting;
  assign m_tdata  = {{M_PAD_W{1'b0}}, chain_out[0], SLOT_W'(count)};
  assign m_tlast  = count_last;

`ifndef SYNTHESIS
  a_no_input_during_readout: assert property (@(posedge clk) disable iff (rst)
    emitting |-> !s_tready)
    else $error("input accepted during frame readout");

  a_fill_saturates: assert property (@(posedge clk) disable iff (rst)
    fill_index <= FW'(FRAME_LEN + 1))
    else $error("fill index beyond saturation");

  a_readout_starts_at_slot_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (count == '0))
    else $error("frame readout did not start at slot zero");

  a_readout_ends_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("readout continued past the last slot");

  a_readout_starts_on_marker: assert property (@(posedge clk) disable iff (rst)
    $rose(emitting) |-> $past(in_acc && armed && hit_second && !hit_first))
    else $error("readout started without a closing marker");
`endif

endmodule

`default_nettype wire

@@ sim/sync_marker_frame_aligner_checker.sv @@
// ----------------------------------------------------------------------------
// Sync marker frame aligner checker
// Watches the register, sample and slot channels of the aligner. It keeps
// its own copy of the marker registers, fill index, arm flag and frame
// store, predicts every slot beat from the accepted samples, and compares
// each slot beat leaving the block field by field with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sync_marker_frame_aligner_checker #(
  parameter int FRAME_LEN = smfa_pkg::FRAME_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  // sample [15:0]
  input  logic [smfa_pkg::SAMPLE_W-1:0]       s_tdata,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  // slot [3:0], frame_sample [19:4], zero padding [23:20]
  input  logic [smfa_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                                m_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [smfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smfa_pkg::SAMPLE_W-1:0]       cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  sample_beats,
  output int                                  slot_beats,
  output int                                  frames
);

  typedef struct packed {
    logic [smfa_pkg::SLOT_W-1:0]   slot;
    logic [smfa_pkg::SAMPLE_W-1:0] frame_sample;
    logic                          last;
  } slot_beat_t;

  slot_beat_t slots_due[$];

  logic signed [smfa_pkg::SAMPLE_W-1:0] marker_first;
  logic signed [smfa_pkg::SAMPLE_W-1:0] marker_second;
  logic [smfa_pkg::TOL_W-1:0]           tolerance;

  int                                   fill_count;
  bit                                   armed;
  logic [smfa_pkg::SAMPLE_W-1:0]        frame_store [FRAME_LEN];

  int mismatch_count = 0;
  int sample_count   = 0;
  int slot_count     = 0;
  int frame_count    = 0;

  initial begin
    errors       = 0;
    pending      = 0;
    sample_beats = 0;
    slot_beats   = 0;
    frames       = 0;
  end

  function automatic bit near_marker(input int s, input int m);
    int t;
    t = int'(tolerance);
    return (s >= m - t) && (s <= m + t);
  endfunction

  task automatic align_sample(input logic [smfa_pkg::SAMPLE_W-1:0] word);
    int         s;
    slot_beat_t beat;
    s = int'($signed(word));
    if (fill_count < FRAME_LEN) frame_store[fill_count] = word;
    if (fill_count < FRAME_LEN + 1) fill_count++;
    if (!armed) begin
      if (near_marker(s, int'(marker_first))) armed = 1'b1;
    end else if (near_marker(s, int'(marker_first))) begin
      armed = 1'b1;
    end else if (near_marker(s, int'(marker_second))) begin
      if (fill_count == FRAME_LEN) begin
        for (int k = 0; k < FRAME_LEN; k++) begin
          beat.slot         = k[smfa_pkg::SLOT_W-1:0];
          beat.frame_sample = frame_store[k];
          beat.last         = (k == FRAME_LEN - 1);
          slots_due.push_back(beat);
        end
      end
      armed      = 1'b0;
      fill_count = 0;
    end else begin
      armed = 1'b0;
    end
  endtask

  task automatic check_slot_beat();
    slot_beat_t want;
    logic [smfa_pkg::SLOT_W-1:0]   got_slot;
    logic [smfa_pkg::SAMPLE_W-1:0] got_sample;
    got_slot   = m_tdata[smfa_pkg::SLOT_W-1:0];
    got_sample = m_tdata[smfa_pkg::SLOT_W +: smfa_pkg::SAMPLE_W];
    slot_count++;
    if (m_tlast) frame_count++;
    if (slots_due.size() == 0) begin
      mismatch_count++;
      $display("%0t: slot beat with none due, expected nothing, got slot %0d sample %0d last %0b",
               $time, got_slot, $signed(got_sample), m_tlast);
    end else begin
      want = slots_due.pop_front();
      if (got_slot !== want.slot) begin
        mismatch_count++;
        $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, got_slot);
      end
      if (got_sample !== want.frame_sample) begin
        mismatch_count++;
        $display("%0t: frame_sample mismatch in slot %0d, expected %0d, got %0d", $time,
                 want.slot, $signed(want.frame_sample), $signed(got_sample));
      end
      if (m_tlast !== want.last) begin
        mismatch_count++;
        $display("%0t: last mismatch in slot %0d, expected %0b, got %0b", $time,
                 want.slot, want.last, m_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      marker_first  = smfa_pkg::MARKER_FIRST_RST;
      marker_second = smfa_pkg::MARKER_SECOND_RST;
      tolerance     = smfa_pkg::TOLERANCE_RST;
      fill_count    = 0;
      armed         = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smfa_pkg::REG_MARKER_FIRST: begin
            marker_first = cfg_data;
          end
          smfa_pkg::REG_MARKER_SECOND: begin
            marker_second = cfg_data;
          end
          smfa_pkg::REG_TOLERANCE: begin
            tolerance = cfg_data[smfa_pkg::TOL_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        sample_count++;
        align_sample(s_tdata);
      end
      if (m_tvalid && m_tready) check_slot_beat();
    end
    pending      <= slots_due.size();
    errors       <= mismatch_count;
    sample_beats <= sample_count;
    slot_beats   <= slot_count;
    frames       <= frame_count;
  end

endmodule

@@ sim/sync_marker_frame_aligner_core_test.sv @@
// ----------------------------------------------------------------------------
// Sync marker frame aligner testbench
// Drives marker-bounded sample frames, broken and overlong frames and noise
// into the aligner under several marker and tolerance settings, with random
// idling on both streams and one long output hold-off. The checker beside
// the block predicts and compares every slot beat; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sync_marker_frame_aligner_core_test;

  localparam int FRAME_LEN   = smfa_pkg::FRAME_LEN_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 160;
  localparam int HOLD_CYCLES = 150;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  logic [smfa_pkg::SAMPLE_W-1:0]      s_tdata   = '0;
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  logic [smfa_pkg::M_TDATA_W-1:0]     m_tdata;
  logic                               m_tlast;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [smfa_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [smfa_pkg::SAMPLE_W-1:0]      cfg_data  = '0;

  int errors;
  int pending;
  int sample_beats;
  int slot_beats;
  int frames;

  int beats_sent  = 0;
  int cycle_count = 0;
  bit idle_on     = 1'b1;
  bit held        = 1'b0;

  int first_now = int'(smfa_pkg::MARKER_FIRST_RST);
  int second_now = int'(smfa_pkg::MARKER_SECOND_RST);
  int tol_now   = int'(smfa_pkg::TOLERANCE_RST);

  sync_marker_frame_aligner_core #(
    .FRAME_LEN (FRAME_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sync_marker_frame_aligner_checker #(
    .FRAME_LEN (FRAME_LEN)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .sample_beats (sample_beats),
    .slot_beats   (slot_beats),
    .frames       (frames)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The output side: random ready bursts, and once a long hold-off so that
  // a finished frame backs up and the block stops taking samples.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!held && beats_sent >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic logic [15:0] word_at(input int m, input int off);
    int v;
    v = m + off;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] marker_like(input int m);
    int off;
    if ($urandom_range(0, 3) == 0) off = $urandom_range(0, 1) ? tol_now : -tol_now;
    else off = int'($urandom_range(0, 2 * tol_now)) - tol_now;
    return word_at(m, off);
  endfunction

  task automatic send_sample(input logic [15:0] word);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic send_fillers(input int n);
    repeat (n) send_sample(16'($urandom));
  endtask

  task automatic send_close();
    send_sample(marker_like(first_now));
    send_sample(marker_like(second_now));
  endtask

  task automatic send_frame();
    send_fillers(FRAME_LEN - 2);
    send_close();
  endtask

  task automatic send_broken();
    case ($urandom_range(0, 4))
      0: begin
        send_fillers($urandom_range(0, FRAME_LEN - 3));
        send_close();
      end
      1: begin
        send_fillers($urandom_range(FRAME_LEN - 1, FRAME_LEN + 4));
        send_close();
      end
      2: begin
        send_fillers($urandom_range(0, FRAME_LEN - 4));
        send_sample(marker_like(first_now));
        send_fillers(1);
        send_sample(marker_like(second_now));
        send_close();
      end
      3: begin
        send_fillers($urandom_range(0, FRAME_LEN - 3));
        send_sample(word_at(first_now, ($urandom_range(0, 1) ? 1 : -1) *
                                       (tol_now + int'($urandom_range(1, 8)))));
        send_sample(marker_like(second_now));
        send_close();
      end
      default: begin
        repeat ($urandom_range(1, 20)) begin
          case ($urandom_range(0, 2))
            0: send_sample(marker_like(first_now));
            1: send_sample(marker_like(second_now));
            default: send_fillers(1);
          endcase
        end
        send_close();
      end
    endcase
  endtask

  task automatic run_random(input int upto);
    send_close();
    while (beats_sent < upto) begin
      if ($urandom_range(0, 9) < 7) send_frame();
      else send_broken();
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (FRAME_LEN + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [smfa_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input int first_m, input int second_m, input logic [15:0] tol_word);
    first_now  = first_m;
    second_now = second_m;
    tol_now    = int'(tol_word[smfa_pkg::TOL_W-1:0]);
    write_reg(smfa_pkg::REG_MARKER_FIRST, 16'(first_m));
    write_reg(smfa_pkg::REG_MARKER_SECOND, 16'(second_m));
    write_reg(smfa_pkg::REG_TOLERANCE, tol_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int tol_r;
    int first_r;
    int second_r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default markers: extreme fillers and a frame closed on the tolerance edges.
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0001);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    send_sample(16'h1234);
    send_sample(word_at(first_now, -tol_now));
    send_sample(word_at(second_now, tol_now));
    // Too short a frame, then a first marker just out of reach.
    send_sample(word_at(first_now, tol_now));
    send_sample(word_at(second_now, -tol_now));
    send_sample(word_at(first_now, -tol_now - 1));
    send_sample(word_at(second_now, 0));
    // Disarm on noise, re-arm, stay armed on a repeated first marker,
    // disarm on a near miss of the second, then close short.
    send_sample(word_at(first_now, 0));
    send_sample(16'h0000);
    send_sample(word_at(first_now, 0));
    send_sample(word_at(first_now, 1));
    send_sample(word_at(second_now, tol_now + 1));
    send_sample(word_at(first_now, 0));
    send_sample(word_at(second_now, 0));
    run_random(110);
    drain();

    apply_setting(-32768, 32767, 16'd0);
    run_random(210);
    drain();

    // Markers so close that their windows overlap.
    apply_setting(1000, 1004, 16'd3);
    run_random(250);
    drain();

    write_reg(2'd3, 16'($urandom));
    apply_setting(32767, -32768, 16'hFFFF);
    run_random(340);
    drain();

    tol_r    = $urandom_range(0, 1023);
    first_r  = -32768 + int'($urandom_range(0, 30000));
    second_r = first_r + 2 * tol_r + 2 + int'($urandom_range(0, 30000));
    apply_setting(first_r, second_r, 16'(($urandom_range(0, 63) << 10) | tol_r));
    idle_on = 1'b0;
    run_random(430);
    drain();

    $display("Sent %0d samples under five marker and tolerance settings; checked %0d slot beats",
             sample_beats, slot_beats);
    $display("in %0d frames, with short, overlong and broken frames and one long output hold-off.",
             frames);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending != 0) $display("%0t: %0d slot beats still due at the end", $time, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
